/* hw/rtl/bcc_pkg.sv */
// Shared types and constants for the button click classifier.
// No dependencies; imported by bcc_core and button_click_classifier.
`default_nettype none

package bcc_pkg;

  // timestamp and window widths
  localparam int unsigned TimeW = 63;
  localparam int unsigned WinW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgActiveLevel  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounceWin  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLongPress    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDoubleWin    = 2'd3;

  // register reset values
  localparam logic            RstActiveLevel = 1'b0;
  localparam logic [WinW-1:0] RstDebounceWin = 32'd50000;
  localparam logic [WinW-1:0] RstLongPress   = 32'd1000000;
  localparam logic [WinW-1:0] RstDoubleWin   = 32'd300000;

  typedef enum logic [2:0] {
    EvNone    = 3'd0,
    EvPress   = 3'd1,
    EvLong    = 3'd2,
    EvRelease = 3'd3,
    EvDouble  = 3'd4,
    EvClick   = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    StIdle     = 2'd0,
    StPressed  = 2'd1,
    StReleased = 2'd2,
    StHeld     = 2'd3
  } state_e;

  // configuration seen by the core
  typedef struct packed {
    logic            active_level;
    logic [WinW-1:0] debounce_window;
    logic [WinW-1:0] long_press_time;
    logic [WinW-1:0] double_click_window;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic   level_echo;
    state_e machine_state;
    event_e event_code;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/bcc_core.sv */
// Classifier state machine: elapsed time, transition logic, state registers.
// Depends on bcc_pkg.
`default_nettype none

module bcc_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [bcc_pkg::TimeW-1:0] now_time_i,
  input  wire logic               pin_level_i,
  input  wire bcc_pkg::cfg_t      cfg_i,
  output bcc_pkg::result_t        result_o
);
  import bcc_pkg::*;

  state_e               state_q, state_d;
  logic [TimeW-1:0]     last_q;
  logic                 stamp;
  event_e               ev;
  logic                 active;
  logic signed [TimeW:0] elapsed;
  logic signed [TimeW:0] deb_s, long_s, dbl_s;
  logic                 lt_deb, gt_long, lt_dbl;

  // elapsed time is exact as a signed value one bit wider than the stamps
  assign active  = (pin_level_i == cfg_i.active_level);
  assign elapsed = $signed({1'b0, now_time_i}) - $signed({1'b0, last_q});
  assign deb_s   = $signed({{(TimeW+1-WinW){1'b0}}, cfg_i.debounce_window});
  assign long_s  = $signed({{(TimeW+1-WinW){1'b0}}, cfg_i.long_press_time});
  assign dbl_s   = $signed({{(TimeW+1-WinW){1'b0}}, cfg_i.double_click_window});
  assign lt_deb  = (elapsed < deb_s);
  assign gt_long = (elapsed > long_s);
  assign lt_dbl  = (elapsed < dbl_s);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (!lt_deb && active) state_d = StPressed;
      end
      StPressed: begin
        if (active && gt_long) state_d = StHeld;
        else if (!active)      state_d = StReleased;
      end
      StReleased: begin
        if (active && lt_dbl) state_d = StHeld;
        else if (!lt_dbl)     state_d = StIdle;
      end
      StHeld: begin
        if (!active) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // event and timestamp capture
  always_comb begin
    ev    = EvNone;
    stamp = 1'b0;
    case (state_q)
      StIdle: begin
        if (!lt_deb && active) begin
          ev    = EvPress;
          stamp = 1'b1;
        end
      end
      StPressed: begin
        if (active && gt_long) begin
          ev    = EvLong;
          stamp = 1'b1;
        end else if (!active) begin
          ev    = EvRelease;
          stamp = 1'b1;
        end
      end
      StReleased: begin
        if (active && lt_dbl) begin
          ev    = EvDouble;
          stamp = 1'b1;
        end else if (!lt_dbl) begin
          ev    = EvClick;
          stamp = 1'b1;
        end
      end
      default: begin
        ev    = EvNone;
        stamp = 1'b0;
      end
    endcase
  end

  assign result_o.event_code    = ev;
  assign result_o.machine_state = state_d;
  assign result_o.level_echo    = pin_level_i;

  // state registers advance once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      if (stamp) last_q <= now_time_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/button_click_classifier.sv */
// Top level of the button click classifier: config registers, stream ports,
// output register with skid stage. Depends on bcc_pkg and bcc_core.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tdata: now_time[62:0], pin_level[63]
//   m_axis    out  m_axis_tvalid/tready       tdata: event_code[2:0],
//                                             machine_state[4:3], level_echo[5]
//   cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One item per cycle while s_axis_tready is high; each item is classified in the
// cycle it is accepted; its result goes to out_q or skid_q. The only loop is
// the state/timestamp register pair fed by one 64-bit subtract and 3 compares.
// Reset returns the machine to idle with a zero last transition time.
// A stalled output fills the skid register; input ready drops while it is full.
`default_nettype none

module button_click_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // now_time[62:0], pin_level[63]
  // stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // event_code[2:0], machine_state[4:3],
                                           // level_echo[5], zero[7:6]
  // config write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [bcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [bcc_pkg::WinW-1:0]    cfg_data_i
);
  import bcc_pkg::*;

  cfg_t    cfg_q;
  result_t res;
  result_t out_q, skid_q;
  logic    out_vld_q, skid_vld_q;
  logic    in_acc, out_take;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level        <= RstActiveLevel;
      cfg_q.debounce_window     <= RstDebounceWin;
      cfg_q.long_press_time     <= RstLongPress;
      cfg_q.double_click_window <= RstDoubleWin;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgActiveLevel: cfg_q.active_level        <= cfg_data_i[0];
        CfgDebounceWin: cfg_q.debounce_window     <= cfg_data_i;
        CfgLongPress:   cfg_q.long_press_time     <= cfg_data_i;
        CfgDoubleWin:   cfg_q.double_click_window <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // classifier
  assign in_acc = s_axis_tvalid && s_axis_tready;

  bcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .now_time_i  (s_axis_tdata[TimeW-1:0]),
    .pin_level_i (s_axis_tdata[TimeW]),
    .cfg_i       (cfg_q),
    .result_o    (res)
  );

  // output register plus skid stage
  assign s_axis_tready = !skid_vld_q;
  assign out_take      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_take) begin
        out_vld_q  <= skid_vld_q || in_acc;
        skid_vld_q <= 1'b0;
      end else if (in_acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_take) begin
      out_q <= skid_vld_q ? skid_q : res;
    end
    if (in_acc && out_vld_q && !out_take) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q};

endmodule

`default_nettype wire
